// ===== src/kcsg_pkg.sv =====
// ----------------------------------------------------------------------------
// kcsg_pkg
// Shared types and constants of the Koch curve segment generator.
// ----------------------------------------------------------------------------
package kcsg_pkg;

    localparam int COORD_BITS  = 16;
    localparam int MAX_ORDER   = 7;
    localparam int ORDER_BITS  = 3;
    localparam int IDX_BITS    = 2 * (MAX_ORDER + 1);
    localparam int SUM_BITS    = COORD_BITS + 2;
    localparam int MUL_BITS    = SUM_BITS;
    localparam int ACC_BITS    = 2 * MUL_BITS;
    localparam int Q_BITS      = 16;
    localparam int RECIP_SHIFT = COORD_BITS + 2;
    localparam int ADDR_BITS   = 5;
    localparam int DATA_BITS   = 32;

    localparam logic signed [MUL_BITS-1:0] RECIP3    = MUL_BITS'(((1 << RECIP_SHIFT) + 2) / 3);
    localparam logic signed [MUL_BITS-1:0] COS_Q16   = MUL_BITS'(32798);
    localparam logic signed [MUL_BITS-1:0] SIN_Q16   = MUL_BITS'(56738);
    localparam logic signed [MUL_BITS-1:0] NSIN_Q16  = -SIN_Q16;
    localparam logic signed [ACC_BITS-1:0] ROT_BIAS  = ACC_BITS'((1 << Q_BITS) - 1);
    localparam logic signed [ACC_BITS-1:0] COORD_MAX = ACC_BITS'((1 << (COORD_BITS - 1)) - 1);
    localparam logic signed [ACC_BITS-1:0] COORD_MIN = -COORD_MAX - ACC_BITS'(1);

    localparam logic [2:0] REG_START_X = 3'd0;
    localparam logic [2:0] REG_START_Y = 3'd1;
    localparam logic [2:0] REG_END_X   = 3'd2;
    localparam logic [2:0] REG_END_Y   = 3'd3;
    localparam logic [2:0] REG_ORDER   = 3'd4;

    localparam logic [1:0] DIG_HEAD = 2'd0;
    localparam logic [1:0] DIG_RISE = 2'd1;
    localparam logic [1:0] DIG_FALL = 2'd2;
    localparam logic [1:0] DIG_TAIL = 2'd3;

    typedef logic signed [COORD_BITS-1:0] coord_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DAX,
        ST_DAY,
        ST_DBX,
        ST_DBY,
        ST_C0,
        ST_C1,
        ST_C2,
        ST_C3,
        ST_LVL,
        ST_DONE
    } kcsg_state_t;

endpackage

// ===== src/koch_curve_segment_generator_unit.sv =====
// ----------------------------------------------------------------------------
// koch_curve_segment_generator_unit
// Emits the segments of a Koch curve in drawing order, one per input item.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+-------------------------------
//   in      | in        | in_valid/in_ready  | restart
//   out     | out       | out_valid/out_ready| seg_x0 seg_y0 seg_x1 seg_y1
//           |           |                    | last_segment
//   cfg     | in        | APB, pready high   | start/end points, curve_order
//
// An item walks curve_order+1 levels through one shared multiply-accumulate
// unit: the thirds on every level, and the apex as well where the digit
// picks a rising or falling side, between an accept and a hand-off state.
// in_ready is low while an item is in work. A finished item waits in the
// output register; a stalled output holds the unit in its final state.
// Reset clears control and config registers and restarts the curve.
// ----------------------------------------------------------------------------
module koch_curve_segment_generator_unit
    import kcsg_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_BITS-1:0] paddr,
    input  logic [DATA_BITS-1:0] pwdata,
    output logic [DATA_BITS-1:0] prdata,
    output logic                 pready,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic                 restart,
    output logic                 out_valid,
    input  logic                 out_ready,
    output coord_t               seg_x0,
    output coord_t               seg_y0,
    output coord_t               seg_x1,
    output coord_t               seg_y1,
    output logic                 last_segment
);

    kcsg_state_t state_reg, state_next;

    coord_t                start_x_reg, start_y_reg, end_x_reg, end_y_reg;
    logic [ORDER_BITS-1:0] order_reg;
    logic [IDX_BITS-1:0]   path_digits_reg, path_digits_next;
    logic                  path_valid_reg, path_valid_next;
    logic [IDX_BITS-1:0]   dig_reg, dig_next;
    logic [ORDER_BITS-1:0] lvl_reg, lvl_next;
    logic                  last_reg, last_next;
    logic                  out_valid_reg, out_valid_next;

    coord_t sx0_reg, sy0_reg, sx1_reg, sy1_reg;
    coord_t ax_reg, ay_reg, bx_reg, by_reg, cx_reg;
    coord_t out_x0_reg, out_y0_reg, out_x1_reg, out_y1_reg;
    logic   out_last_reg;
    logic   div_neg_reg;
    logic signed [ACC_BITS-1:0] acc_reg, acc_next;

    logic                  cfg_wr;
    logic [2:0]            cfg_idx;
    logic [ORDER_BITS-1:0] n_eff;
    logic [IDX_BITS-1:0]   last_mask;
    logic [IDX_BITS-1:0]   idx_start;
    logic                  accept;
    logic                  emit;
    logic [1:0]            digit;
    logic                  need_c;

    coord_t                     div_p, div_q;
    logic signed [SUM_BITS-1:0] div_sum, div_mag;
    logic signed [SUM_BITS-1:0] dx, dy;
    logic signed [MUL_BITS-1:0] mul_a, mul_b;
    logic signed [ACC_BITS-1:0] mul_base, prod;
    logic                       mul_en;

    logic [COORD_BITS:0]          q_mag;
    logic signed [COORD_BITS+1:0] q_wide;
    coord_t                       div_res;
    logic signed [ACC_BITS-1:0]   rot_tmp, rot_sh;
    coord_t                       rot_res;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[ADDR_BITS-1:2];

    always_comb
    begin
        case (cfg_idx)
            REG_START_X: prdata = DATA_BITS'($unsigned(start_x_reg));
            REG_START_Y: prdata = DATA_BITS'($unsigned(start_y_reg));
            REG_END_X:   prdata = DATA_BITS'($unsigned(end_x_reg));
            REG_END_Y:   prdata = DATA_BITS'($unsigned(end_y_reg));
            REG_ORDER:   prdata = DATA_BITS'(order_reg);
            default:     prdata = '0;
        endcase
    end

    assign n_eff = (order_reg > ORDER_BITS'(MAX_ORDER)) ? ORDER_BITS'(MAX_ORDER) : order_reg;

    always_comb
    begin
        for (int i = 0; i < IDX_BITS; i++)
        begin
            last_mask[i] = (i < (2 * int'(n_eff) + 2));
        end
    end

    assign idx_start = (restart || !path_valid_reg) ? '0 : (path_digits_reg & last_mask);
    assign in_ready  = (state_reg == ST_IDLE);
    assign accept    = in_valid & in_ready;
    assign emit      = (state_reg == ST_DONE) && (!out_valid_reg || out_ready);
    assign digit     = dig_reg[IDX_BITS-1 -: 2];
    assign need_c    = (digit == DIG_RISE) || (digit == DIG_FALL);

    // shared multiply-accumulate: thirds by reciprocal, apex by rotation
    always_comb
    begin
        case (state_reg)
            ST_DAX:  begin div_p = sx0_reg; div_q = sx1_reg; end
            ST_DAY:  begin div_p = sy0_reg; div_q = sy1_reg; end
            ST_DBX:  begin div_p = sx1_reg; div_q = sx0_reg; end
            default: begin div_p = sy1_reg; div_q = sy0_reg; end
        endcase
    end

    assign div_sum = (SUM_BITS'(div_p) <<< 1) + SUM_BITS'(div_q);
    assign div_mag = div_sum[SUM_BITS-1] ? -div_sum : div_sum;
    assign dx      = SUM_BITS'(bx_reg) - SUM_BITS'(ax_reg);
    assign dy      = SUM_BITS'(by_reg) - SUM_BITS'(ay_reg);

    always_comb
    begin
        mul_en   = 1'b1;
        mul_a    = div_mag;
        mul_b    = RECIP3;
        mul_base = '0;
        case (state_reg)
            ST_DAX, ST_DAY, ST_DBX, ST_DBY:
            begin
                mul_a = div_mag;
            end
            ST_C0:
            begin
                mul_a    = dx;
                mul_b    = COS_Q16;
                mul_base = ACC_BITS'(ax_reg) <<< Q_BITS;
            end
            ST_C1:
            begin
                mul_a    = dy;
                mul_b    = SIN_Q16;
                mul_base = acc_reg;
            end
            ST_C2:
            begin
                mul_a    = dx;
                mul_b    = NSIN_Q16;
                mul_base = ACC_BITS'(ay_reg) <<< Q_BITS;
            end
            ST_C3:
            begin
                mul_a    = dy;
                mul_b    = COS_Q16;
                mul_base = acc_reg;
            end
            default:
            begin
                mul_en = 1'b0;
            end
        endcase
    end

    assign prod     = mul_a * mul_b;
    assign acc_next = mul_en ? (mul_base + prod) : acc_reg;

    assign q_mag   = acc_reg[RECIP_SHIFT +: COORD_BITS+1];
    assign q_wide  = div_neg_reg ? -$signed({1'b0, q_mag}) : $signed({1'b0, q_mag});
    assign div_res = q_wide[COORD_BITS-1:0];

    assign rot_tmp = acc_reg + (acc_reg[ACC_BITS-1] ? ROT_BIAS : '0);
    assign rot_sh  = rot_tmp >>> Q_BITS;

    always_comb
    begin
        if (rot_sh > COORD_MAX)
        begin
            rot_res = COORD_MAX[COORD_BITS-1:0];
        end
        else if (rot_sh < COORD_MIN)
        begin
            rot_res = COORD_MIN[COORD_BITS-1:0];
        end
        else
        begin
            rot_res = rot_sh[COORD_BITS-1:0];
        end
    end

    // sequencer
    always_comb
    begin
        state_next       = state_reg;
        path_digits_next = path_digits_reg;
        path_valid_next  = path_valid_reg;
        dig_next         = dig_reg;
        lvl_next         = lvl_reg;
        last_next        = last_reg;
        out_valid_next   = out_valid_reg & ~out_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next       = ST_DAX;
                    lvl_next         = n_eff;
                    dig_next         = idx_start << (2 * (MAX_ORDER - int'(n_eff)));
                    last_next        = (idx_start == last_mask);
                    path_digits_next = (idx_start == last_mask) ? '0 : idx_start + 1'b1;
                    path_valid_next  = 1'b1;
                end
            end
            ST_DAX: state_next = ST_DAY;
            ST_DAY: state_next = ST_DBX;
            ST_DBX: state_next = ST_DBY;
            ST_DBY: state_next = need_c ? ST_C0 : ST_LVL;
            ST_C0:  state_next = ST_C1;
            ST_C1:  state_next = ST_C2;
            ST_C2:  state_next = ST_C3;
            ST_C3:  state_next = ST_LVL;
            ST_LVL:
            begin
                if (lvl_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_DAX;
                    lvl_next   = lvl_reg - 1'b1;
                    dig_next   = dig_reg << 2;
                end
            end
            ST_DONE:
            begin
                if (emit)
                begin
                    state_next     = ST_IDLE;
                    out_valid_next = 1'b1;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cfg_wr && (cfg_idx <= REG_ORDER))
        begin
            path_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            path_digits_reg <= '0;
            path_valid_reg  <= 1'b0;
            dig_reg         <= '0;
            lvl_reg         <= '0;
            last_reg        <= 1'b0;
            out_valid_reg   <= 1'b0;
            start_x_reg     <= '0;
            start_y_reg     <= '0;
            end_x_reg       <= '0;
            end_y_reg       <= '0;
            order_reg       <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            path_digits_reg <= path_digits_next;
            path_valid_reg  <= path_valid_next;
            dig_reg         <= dig_next;
            lvl_reg         <= lvl_next;
            last_reg        <= last_next;
            out_valid_reg   <= out_valid_next;
            if (cfg_wr)
            begin
                case (cfg_idx)
                    REG_START_X: start_x_reg <= pwdata[COORD_BITS-1:0];
                    REG_START_Y: start_y_reg <= pwdata[COORD_BITS-1:0];
                    REG_END_X:   end_x_reg   <= pwdata[COORD_BITS-1:0];
                    REG_END_Y:   end_y_reg   <= pwdata[COORD_BITS-1:0];
                    REG_ORDER:   order_reg   <= pwdata[ORDER_BITS-1:0];
                    default:     ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        case (state_reg)
            ST_IDLE:
            begin
                sx0_reg <= start_x_reg;
                sy0_reg <= start_y_reg;
                sx1_reg <= end_x_reg;
                sy1_reg <= end_y_reg;
            end
            ST_DAX: div_neg_reg <= div_sum[SUM_BITS-1];
            ST_DAY:
            begin
                div_neg_reg <= div_sum[SUM_BITS-1];
                ax_reg      <= div_res;
            end
            ST_DBX:
            begin
                div_neg_reg <= div_sum[SUM_BITS-1];
                ay_reg      <= div_res;
            end
            ST_DBY:
            begin
                div_neg_reg <= div_sum[SUM_BITS-1];
                bx_reg      <= div_res;
            end
            ST_C0: by_reg <= div_res;
            ST_C2: cx_reg <= rot_res;
            ST_LVL:
            begin
                case (digit)
                    DIG_HEAD:
                    begin
                        sx1_reg <= ax_reg;
                        sy1_reg <= ay_reg;
                    end
                    DIG_RISE:
                    begin
                        sx0_reg <= ax_reg;
                        sy0_reg <= ay_reg;
                        sx1_reg <= cx_reg;
                        sy1_reg <= rot_res;
                    end
                    DIG_FALL:
                    begin
                        sx0_reg <= cx_reg;
                        sy0_reg <= rot_res;
                        sx1_reg <= bx_reg;
                        sy1_reg <= by_reg;
                    end
                    default:
                    begin
                        sx0_reg <= bx_reg;
                        sy0_reg <= div_res;
                    end
                endcase
            end
            default: ;
        endcase
        if (emit)
        begin
            out_x0_reg   <= sx0_reg;
            out_y0_reg   <= sy0_reg;
            out_x1_reg   <= sx1_reg;
            out_y1_reg   <= sy1_reg;
            out_last_reg <= last_reg;
        end
    end

    assign out_valid    = out_valid_reg;
    assign seg_x0       = out_x0_reg;
    assign seg_y0       = out_y0_reg;
    assign seg_x1       = out_x1_reg;
    assign seg_y1       = out_y1_reg;
    assign last_segment = out_last_reg;

endmodule

// ===== src/kcsg_checker.sv =====
// ----------------------------------------------------------------------------
// kcsg_checker
// Port-level checks of the Koch curve segment generator.
// ----------------------------------------------------------------------------
module kcsg_checker
    import kcsg_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   pready,
    input logic   in_valid,
    input logic   in_ready,
    input logic   out_valid,
    input logic   out_ready,
    input coord_t seg_x0,
    input coord_t seg_y1,
    input logic   last_segment
);

    a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
        pready)
        else $error("pready dropped");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready ##1 !in_ready ##1 !in_ready)
        else $error("new item taken while one is in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output item dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(seg_x0) && $stable(seg_y1)
                                    && $stable(last_segment))
        else $error("output item changed while stalled");

endmodule

bind koch_curve_segment_generator_unit kcsg_checker u_kcsg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .seg_x0       (seg_x0),
    .seg_y1       (seg_y1),
    .last_segment (last_segment)
);

// ===== tb/sv/koch_curve_segment_generator_unit_tb.sv =====
// ----------------------------------------------------------------------------
// koch_curve_segment_generator_unit_tb
// Drives restart items and APB register writes into the Koch curve segment
// generator. A directed table comes first: the all-zero curve after reset,
// a short line with hand-worked segments, full-scale endpoints at the top
// order, a saturating apex and a write beyond the register map. Random
// phases follow. Every segment that comes out is compared field by field
// with a listed value or behavioral model of thirds, apex rotation, path.
// ----------------------------------------------------------------------------
module koch_curve_segment_generator_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import kcsg_pkg::*;

    localparam logic [2:0] REG_SPARE  = 3'd5;
    localparam longint     ROT_COS    = COS_Q16;
    localparam longint     ROT_SIN    = SIN_Q16;
    localparam int         STALL_MAX  = 2000;
    localparam int         CHOKE_LEN  = 300;
    localparam int         ITEM_GOAL  = 620;

    typedef enum logic {ROW_ITEM, ROW_REG} row_kind_t;

    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        logic   last;
    } segment_t;

    typedef struct {
        longint x0;
        longint y0;
        longint x1;
        longint y1;
    } span_t;

    typedef struct packed {
        row_kind_t            kind;
        logic [ADDR_BITS-1:0] addr;
        logic [31:0]          data;
        logic                 rs;
        logic                 lit;
        segment_t             want;
    } plan_row_t;

    localparam segment_t SEG_ZERO      = '0;
    localparam segment_t SEG_ZERO_LAST = '{16'sd0, 16'sd0, 16'sd0, 16'sd0, 1'b1};

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 psel      = 1'b0;
    logic                 penable   = 1'b0;
    logic                 pwrite    = 1'b0;
    logic [ADDR_BITS-1:0] paddr     = '0;
    logic [DATA_BITS-1:0] pwdata    = '0;
    logic [DATA_BITS-1:0] prdata;
    logic                 pready;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    logic                 restart   = 1'b0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    coord_t               seg_x0;
    coord_t               seg_y0;
    coord_t               seg_x1;
    coord_t               seg_y1;
    logic                 last_segment;

    coord_t      cfg_sx = '0;
    coord_t      cfg_sy = '0;
    coord_t      cfg_ex = '0;
    coord_t      cfg_ey = '0;
    logic [2:0]  cfg_order = '0;
    int unsigned cursor = 0;
    logic        cursor_valid = 1'b0;

    segment_t pending_segs[$];
    int       segs_issued  = 0;
    int       segs_drawn   = 0;
    int       curve_faults = 0;
    int       quiet_cycles = 0;
    int       hold_left    = 0;
    logic     choke_go     = 1'b0;
    logic     choke_done   = 1'b0;
    logic [15:0] rim_vals [4] = '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF};

    plan_row_t plan[$] = '{
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b1, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b1, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b1, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b1, SEG_ZERO_LAST},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b1, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b1, 1'b1, SEG_ZERO},
        '{ROW_REG, {REG_END_X, 2'b00}, 32'd3, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b1, '{16'sd0, 16'sd0, 16'sd1, 16'sd0, 1'b0}},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b1, '{16'sd1, 16'sd0, 16'sd1, 16'sd0, 1'b0}},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b1, '{16'sd1, 16'sd0, 16'sd2, 16'sd0, 1'b0}},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b1, '{16'sd2, 16'sd0, 16'sd3, 16'sd0, 1'b1}},
        '{ROW_REG, {REG_START_X, 2'b00}, 32'hFFFF_8000, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_REG, {REG_START_Y, 2'b00}, 32'h0000_7FFF, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_REG, {REG_END_X, 2'b00}, 32'h0000_7FFF, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_REG, {REG_END_Y, 2'b00}, 32'hFFFF_8000, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_REG, {REG_ORDER, 2'b00}, 32'hFFFF_FFFF, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b1, 1'b0, SEG_ZERO},
        '{ROW_REG, {REG_START_X, 2'b00}, 32'h0000_7FFF, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_REG, {REG_END_X, 2'b00}, 32'h0000_8000, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_REG, {REG_END_Y, 2'b00}, 32'h0000_7FFF, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_REG, {REG_ORDER, 2'b00}, 32'h0000_0000, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_REG, {REG_SPARE, 2'b00}, 32'hFFFF_FFFF, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b0, SEG_ZERO},
        '{ROW_ITEM, 5'd0, 32'd0, 1'b0, 1'b0, SEG_ZERO}
    };

    koch_curve_segment_generator_unit dut (.*);

    always #1 clk = ~clk;

    function automatic longint clamp_coord(longint v);
        longint hi;
        hi = (longint'(1) << (COORD_BITS - 1)) - 1;
        if (v > hi) return hi;
        if (v < -hi - 1) return -hi - 1;
        return v;
    endfunction

    function automatic span_t third_split(span_t s, logic [1:0] dig);
        longint ax, ay, bx, by, dx, dy, cx, cy;
        span_t  r;
        ax = (2 * s.x0 + s.x1) / 3;
        ay = (2 * s.y0 + s.y1) / 3;
        bx = (2 * s.x1 + s.x0) / 3;
        by = (2 * s.y1 + s.y0) / 3;
        dx = bx - ax;
        dy = by - ay;
        cx = clamp_coord((ax * 65536 + dx * ROT_COS + dy * ROT_SIN) / 65536);
        cy = clamp_coord((ay * 65536 - dx * ROT_SIN + dy * ROT_COS) / 65536);
        case (dig)
            DIG_HEAD: r = '{s.x0, s.y0, ax, ay};
            DIG_RISE: r = '{ax, ay, cx, cy};
            DIG_FALL: r = '{cx, cy, bx, by};
            default:  r = '{bx, by, s.x1, s.y1};
        endcase
        return r;
    endfunction

    function automatic segment_t koch_next_segment(logic rs);
        int unsigned top, last_idx, idx;
        int          lvl;
        span_t       s;
        segment_t    r;
        top = cfg_order;
        if (top > MAX_ORDER) top = MAX_ORDER;
        last_idx = (32'd1 << (2 * (top + 1))) - 1;
        if (rs || !cursor_valid) cursor = 0;
        idx = cursor & last_idx;
        s = '{cfg_sx, cfg_sy, cfg_ex, cfg_ey};
        for (lvl = 0; lvl <= top; lvl++)
            s = third_split(s, 2'(idx >> (2 * (top - lvl))));
        r.x0 = coord_t'(s.x0);
        r.y0 = coord_t'(s.y0);
        r.x1 = coord_t'(s.x1);
        r.y1 = coord_t'(s.y1);
        r.last = (idx == last_idx);
        cursor = r.last ? 0 : idx + 1;
        cursor_valid = 1'b1;
        return r;
    endfunction

    task automatic check_field(input string tag, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch: expected %0d, actual %0d", $time, tag, want, got);
            curve_faults++;
        end
    endtask

    task automatic settle(input int slack);
        in_valid <= 1'b0;
        while (pending_segs.size() != 0) @(posedge clk);
        repeat (slack) @(posedge clk);
    endtask

    task automatic reg_write(input logic [ADDR_BITS-1:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (addr[4:2])
            REG_START_X: begin cfg_sx = coord_t'(data[15:0]); cursor_valid = 1'b0; end
            REG_START_Y: begin cfg_sy = coord_t'(data[15:0]); cursor_valid = 1'b0; end
            REG_END_X:   begin cfg_ex = coord_t'(data[15:0]); cursor_valid = 1'b0; end
            REG_END_Y:   begin cfg_ey = coord_t'(data[15:0]); cursor_valid = 1'b0; end
            REG_ORDER:   begin cfg_order = data[2:0]; cursor_valid = 1'b0; end
            default:     ;
        endcase
        @(posedge clk);
    endtask

    task automatic push_restart(input logic rs, input logic lit, input segment_t want);
        segment_t seg;
        if (!(segs_issued >= 300 && segs_issued < 400)) begin
            while ($urandom_range(99) < 29) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        restart  <= rs;
        do @(posedge clk); while (!in_ready);
        seg = koch_next_segment(rs);
        pending_segs.push_back(lit ? want : seg);
        segs_issued++;
    endtask

    always @(posedge clk) begin
        segment_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_segs.size() == 0) begin
                $display("%0t: unexpected segment: expected none, actual (%0d,%0d)-(%0d,%0d) last %0d",
                         $time, seg_x0, seg_y0, seg_x1, seg_y1, last_segment);
                curve_faults++;
            end else begin
                want = pending_segs.pop_front();
                check_field("seg_x0", want.x0, seg_x0);
                check_field("seg_y0", want.y0, seg_y0);
                check_field("seg_x1", want.x1, seg_x1);
                check_field("seg_y1", want.y1, seg_y1);
                check_field("last_segment", want.last, last_segment);
            end
            segs_drawn++;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_ready <= 1'b0;
        end else if (choke_go && !choke_done) begin
            hold_left  = CHOKE_LEN;
            choke_done = 1'b1;
            out_ready <= 1'b0;
        end else if (segs_drawn >= 300 && segs_drawn < 400) begin
            out_ready <= 1'b1;
        end else begin
            out_ready <= ($urandom_range(99) >= 29);
        end
    end

    always @(posedge clk) begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || psel) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_MAX) begin
                $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    initial begin
        plan_row_t   row;
        int          phase;
        int          burst;
        int          nregs;
        logic [2:0]  slot;
        logic [31:0] word;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[k]) begin
            row = plan[k];
            if (row.kind == ROW_REG) begin
                settle(4);
                reg_write(row.addr, row.data);
            end else begin
                push_restart(row.rs, row.lit, row.want);
            end
        end

        phase = 0;
        while (segs_issued < ITEM_GOAL) begin
            settle(4);
            nregs = $urandom_range(3, 1);
            repeat (nregs) begin
                word = $urandom;
                if ($urandom_range(9) == 0) begin
                    slot = 3'($urandom_range(7, 5));
                end else begin
                    slot = 3'($urandom_range(4));
                end
                if (slot == REG_ORDER) begin
                    word[2:0] = ($urandom_range(99) < 85) ? 3'($urandom_range(2))
                                                          : 3'($urandom_range(7, 3));
                end else if ($urandom_range(3) == 0) begin
                    word[15:0] = rim_vals[$urandom_range(3)];
                end
                reg_write({slot, 2'b00}, word);
            end
            burst = $urandom_range(60, 10);
            if (phase == 4) begin
                choke_go = 1'b1;
                burst = 40;
            end
            repeat (burst) push_restart($urandom_range(99) < 6, 1'b0, SEG_ZERO);
            phase++;
        end

        settle(80);
        if (curve_faults == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
